// ===== sv/sod_pkg.sv =====
package sod_pkg;

  localparam int WhiteWindowDefault = 4;
  localparam int DarkWindowDefault  = 5;
  localparam int EdgeBackoffDefault = 5;

  localparam int PixW    = 8;
  localparam int CoordW  = 10;
  localparam int WhiteThW = 10;
  localparam int DarkThW  = 11;
  localparam int CfgIdxW  = 3;
  localparam int CfgDataW = 11;

  localparam logic [WhiteThW-1:0] WhiteThReset  = 10'd60;
  localparam logic [DarkThW-1:0]  DarkThReset   = 11'd30;
  localparam logic [CoordW-1:0]   StartRowReset = 10'd150;
  localparam logic [CoordW-1:0]   StopRowReset  = 10'd100;
  localparam logic [CoordW-1:0]   StartColReset = 10'd240;
  localparam logic [CoordW-1:0]   MinColReset   = 10'd10;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_WHITE_TH  = 3'd0,
    CFG_DARK_TH   = 3'd1,
    CFG_START_ROW = 3'd2,
    CFG_STOP_ROW  = 3'd3,
    CFG_START_COL = 3'd4,
    CFG_MIN_COL   = 3'd5
  } cfg_idx_t;

  typedef enum logic [1:0] {
    PH_WHITE1 = 2'd0,
    PH_DARK   = 2'd1,
    PH_WHITE2 = 2'd2
  } phase_t;

  typedef struct packed {
    logic [PixW-1:0]   pixel;
    logic [CoordW-1:0] col;
    logic [CoordW-1:0] row;
    logic              row_start;
    logic              frame_end;
  } pixel_req_t;

  typedef struct packed {
    logic [CoordW-1:0] right_edge;
    logic              right_found;
    logic [CoordW-1:0] right_edge_row;
    logic [CoordW-1:0] left_edge;
    logic              left_found;
  } result_t;

  typedef struct packed {
    logic [CfgIdxW-1:0]  index;
    logic [CfgDataW-1:0] data;
  } cfg_req_t;

endpackage

// ===== sv/sod_chan_if.sv =====
interface sod_chan_if #(
  parameter type T = logic
) ();
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== sv/scanline_obstacle_detector_top.sv =====
// Scanline obstacle detector. Takes one pixel request per clock cycle on pix_in, in scan
// order (rows bottom to top, each row right to left), and runs a white/dark/white search
// over a short pixel window inside the configured rows and columns. A result appears on
// res_out in the cycle after the pixel completing the pattern, or after the frame-end
// pixel when no pattern was found; at most one result per frame. The result sits in an
// output register, so pix_in stays ready while that register is empty or being taken;
// it drops only while a result waits on a stalled res_out. Configuration writes on cfg
// are taken every cycle and must be made while the block is idle.
module scanline_obstacle_detector_top #(
  parameter int WHITE_WINDOW = sod_pkg::WhiteWindowDefault,
  parameter int DARK_WINDOW  = sod_pkg::DarkWindowDefault,
  parameter int EDGE_BACKOFF = sod_pkg::EdgeBackoffDefault
) (
  input  logic       clk,
  input  logic       rst,
  sod_chan_if.sink   pix_in,
  sod_chan_if.source res_out,
  sod_chan_if.sink   cfg
);

  localparam int WinDepth = (WHITE_WINDOW > DARK_WINDOW) ? WHITE_WINDOW : DARK_WINDOW;
  localparam int SumW     = sod_pkg::PixW + $clog2(WinDepth + 1);
  localparam int CmpW     = (SumW > sod_pkg::DarkThW) ? SumW : sod_pkg::DarkThW;
  localparam logic [sod_pkg::CoordW-1:0] Backoff = sod_pkg::CoordW'(EDGE_BACKOFF);

  logic [sod_pkg::WhiteThW-1:0] white_th;
  logic [sod_pkg::DarkThW-1:0]  dark_th;
  logic [sod_pkg::CoordW-1:0]   start_row, stop_row, start_col, min_col;

  logic [sod_pkg::PixW-1:0] window [WinDepth];
  logic [sod_pkg::PixW-1:0] window_next [WinDepth];
  sod_pkg::phase_t          phase, phase_next;
  logic [sod_pkg::CoordW-1:0] held_right_edge, held_right_edge_next;
  logic [sod_pkg::CoordW-1:0] held_right_row, held_right_row_next;
  logic                       held_right_found, held_right_found_next;
  logic                       frame_done, frame_done_next;

  logic                res_valid;
  sod_pkg::result_t    res_data, res_calc;
  logic                emit;

  sod_pkg::pixel_req_t req;
  logic                accept;
  logic [SumW-1:0]     white_sum, dark_sum;
  logic                is_white, is_dark, in_area;
  logic [sod_pkg::CoordW-1:0] edge_col;

  assign req          = pix_in.data;
  assign pix_in.ready = !res_valid || res_out.ready;
  assign accept       = pix_in.valid && pix_in.ready;
  assign cfg.ready    = 1'b1;
  assign res_out.valid = res_valid;
  assign res_out.data  = res_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      white_th  <= sod_pkg::WhiteThReset;
      dark_th   <= sod_pkg::DarkThReset;
      start_row <= sod_pkg::StartRowReset;
      stop_row  <= sod_pkg::StopRowReset;
      start_col <= sod_pkg::StartColReset;
      min_col   <= sod_pkg::MinColReset;
    end else if (cfg.valid) begin
      unique case (cfg.data.index)
        sod_pkg::CFG_WHITE_TH:  white_th  <= cfg.data.data[sod_pkg::WhiteThW-1:0];
        sod_pkg::CFG_DARK_TH:   dark_th   <= cfg.data.data;
        sod_pkg::CFG_START_ROW: start_row <= cfg.data.data[sod_pkg::CoordW-1:0];
        sod_pkg::CFG_STOP_ROW:  stop_row  <= cfg.data.data[sod_pkg::CoordW-1:0];
        sod_pkg::CFG_START_COL: start_col <= cfg.data.data[sod_pkg::CoordW-1:0];
        sod_pkg::CFG_MIN_COL:   min_col   <= cfg.data.data[sod_pkg::CoordW-1:0];
        default: ;
      endcase
    end
  end

  // shifted window: current pixel first, cleared on row start
  always_comb begin
    window_next[0] = req.pixel;
    for (int i = 1; i < WinDepth; i++) begin
      window_next[i] = req.row_start ? '0 : window[i-1];
    end
  end

  always_comb begin
    white_sum = '0;
    dark_sum  = '0;
    for (int i = 0; i < WinDepth; i++) begin
      if (i < WHITE_WINDOW) white_sum = white_sum + SumW'(window_next[i]);
      if (i < DARK_WINDOW)  dark_sum  = dark_sum + SumW'(window_next[i]);
    end
  end

  assign is_white = CmpW'(white_sum) > CmpW'(white_th);
  assign is_dark  = CmpW'(dark_sum) < CmpW'(dark_th);
  assign in_area  = !frame_done && req.row <= start_row && req.row > stop_row &&
                    req.col <= start_col && req.col > min_col;
  assign edge_col = (req.col > Backoff) ? req.col - Backoff : '0;

  always_comb begin
    phase_next            = req.row_start ? sod_pkg::PH_WHITE1 : phase;
    held_right_edge_next  = held_right_edge;
    held_right_row_next   = held_right_row;
    held_right_found_next = held_right_found;
    frame_done_next       = frame_done;
    emit                  = 1'b0;
    res_calc.left_edge    = '0;
    res_calc.left_found   = 1'b0;
    if (in_area) begin
      unique case (phase_next)
        sod_pkg::PH_DARK: begin
          if (is_dark) phase_next = sod_pkg::PH_WHITE2;
        end
        sod_pkg::PH_WHITE2: begin
          if (is_white) begin
            emit                = 1'b1;
            frame_done_next     = 1'b1;
            res_calc.left_edge  = edge_col;
            res_calc.left_found = 1'b1;
          end
        end
        default: begin
          phase_next = sod_pkg::PH_WHITE1;
          if (is_white) begin
            held_right_edge_next  = edge_col;
            held_right_row_next   = req.row;
            held_right_found_next = 1'b1;
            phase_next            = sod_pkg::PH_DARK;
          end
        end
      endcase
    end
    res_calc.right_edge     = held_right_edge_next;
    res_calc.right_found    = held_right_found_next;
    res_calc.right_edge_row = held_right_row_next;
    if (req.frame_end && !frame_done_next) emit = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < WinDepth; i++) window[i] <= '0;
      phase            <= sod_pkg::PH_WHITE1;
      held_right_edge  <= '0;
      held_right_row   <= '0;
      held_right_found <= 1'b0;
      frame_done       <= 1'b0;
    end else if (accept) begin
      if (req.frame_end) begin
        for (int i = 0; i < WinDepth; i++) window[i] <= '0;
        phase            <= sod_pkg::PH_WHITE1;
        held_right_edge  <= '0;
        held_right_row   <= '0;
        held_right_found <= 1'b0;
        frame_done       <= 1'b0;
      end else begin
        window           <= window_next;
        phase            <= phase_next;
        held_right_edge  <= held_right_edge_next;
        held_right_row   <= held_right_row_next;
        held_right_found <= held_right_found_next;
        frame_done       <= frame_done_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (accept && emit) begin
      res_valid <= 1'b1;
    end else if (res_out.ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && emit) res_data <= res_calc;
  end

endmodule
